### hdl/jlsf_pkg.sv
// ----------------------------------------------------------------------------
// jlsf_pkg
// Shared widths, constants, register indexes and sequencer states of the
// jerk-limited speed filter.
// ----------------------------------------------------------------------------
`default_nettype none

package jlsf_pkg;

  localparam int SPEED_W = 15;
  localparam int ACC_W   = 16;
  localparam int LIM_W   = 15;
  localparam int JERK_W  = 16;
  localparam int TIME_W  = 16;
  localparam int CFG_W   = 16;
  localparam int OPND_W  = 16;
  localparam int PROD_W  = 2 * OPND_W;

  localparam logic [OPND_W-1:0]  MS_PER_S   = 16'd1000;
  localparam logic [TIME_W-1:0]  RESP_FLOOR = 16'd50;
  localparam logic [SPEED_W-1:0] SPEED_MAX  = 15'h7fff;
  localparam logic [ACC_W-1:0]   ACC_MAX    = 16'h7fff;
  localparam logic [ACC_W-1:0]   ACC_MIN    = 16'h8000;

  localparam logic [LIM_W-1:0]  ACCEL_LIMIT_RST = 15'd512;
  localparam logic [LIM_W-1:0]  DECEL_LIMIT_RST = 15'd768;
  localparam logic [JERK_W-1:0] JERK_LIMIT_RST  = 16'd1024;
  localparam logic [TIME_W-1:0] RESPONSE_RST    = 16'd500;

  typedef enum logic [1:0] {
    CFG_ACCEL_LIMIT = 2'd0,
    CFG_DECEL_LIMIT = 2'd1,
    CFG_JERK_LIMIT  = 2'd2,
    CFG_RESPONSE_MS = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_ERR,
    ST_DIV_ERR,
    ST_MUL_JERK,
    ST_DIV_JERK,
    ST_ACC,
    ST_LAUNCH,
    ST_MUL_ACC,
    ST_DIV_ACC,
    ST_SNAP,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

### hdl/jlsf_in_if.sv
// ----------------------------------------------------------------------------
// jlsf_in_if
// Request channel of the speed filter: mode, target speed and time step.
// ----------------------------------------------------------------------------
`default_nettype none

interface jlsf_in_if
  import jlsf_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic signed [ACC_W-1:0]  speed_tgt;
  logic        [TIME_W-1:0] step_ms;

  modport source (output valid, mode, speed_tgt, step_ms, input ready);
  modport sink   (input valid, mode, speed_tgt, step_ms, output ready);
endinterface

`default_nettype wire

### hdl/jlsf_out_if.sv
// ----------------------------------------------------------------------------
// jlsf_out_if
// Result channel of the speed filter: speed command and acceleration.
// ----------------------------------------------------------------------------
`default_nettype none

interface jlsf_out_if
  import jlsf_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic        [SPEED_W-1:0] speed_cmd;
  logic signed [ACC_W-1:0]   accel_now;

  modport source (output valid, speed_cmd, accel_now, input ready);
  modport sink   (input valid, speed_cmd, accel_now, output ready);
endinterface

`default_nettype wire

### hdl/jerk_limited_speed_filter_core.sv
// ----------------------------------------------------------------------------
// jerk_limited_speed_filter_core
// Jerk-limited ramp of a Q8.8 speed command toward a target speed.
// ----------------------------------------------------------------------------
// One request is handled at a time. A reset request, the first request after
// power-up and a request with a zero time step go straight to the final step
// and present their result from there, and the input is ready again after it.
// An update request passes through the sequencer states in order; its three
// products go through one shared 16-step shift-add multiplier and its three
// quotients (error times 1000 over response time, jerk times step over 1000,
// and acceleration times step over 1000) through one shared 32-step restoring
// divider. The result sits in an output register, so a new request is taken
// while the last result waits; a finished request then holds in its last step
// until that register is free.
`default_nettype none

module jerk_limited_speed_filter_core
  import jlsf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  jlsf_in_if.sink               in_i,
  jlsf_out_if.source            out_o
);

  state_e state_q, state_d;

  logic [LIM_W-1:0]   accel_lim_q, decel_lim_q;
  logic [JERK_W-1:0]  jerk_lim_q;
  logic [TIME_W-1:0]  resp_q, resp_eff;

  logic               primed_q;
  logic [SPEED_W-1:0] speed_q;
  logic [ACC_W-1:0]   accel_q;

  logic [SPEED_W-1:0] t_q, t_in;
  logic [TIME_W-1:0]  dt_q;
  logic               err_neg_q, err_zero_q;
  logic [ACC_W-1:0]   desired_q, acc_q;
  logic [ACC_W:0]     step_q;
  logic [SPEED_W-1:0] next_q;

  logic               out_valid_q;
  logic [SPEED_W-1:0] out_speed_q;
  logic [ACC_W-1:0]   out_accel_q;

  logic               in_ready, in_fire;
  logic               mul_start, mul_done, div_start, div_done;
  logic [OPND_W-1:0]  mul_a, mul_b, div_den;
  logic [PROD_W-1:0]  mul_prod, div_quo;

  logic               err_neg;
  logic [SPEED_W-1:0] err_mag;
  logic [LIM_W-1:0]   des_lim, des_mag;
  logic [ACC_W-1:0]   desired_d;
  logic [ACC_W:0]     diff, diff_abs, step_d;
  logic [ACC_W-1:0]   diff_mag, step_mag;
  logic [ACC_W+1:0]   acc_sum;
  logic [ACC_W-1:0]   acc_d, acc_mag;
  logic [PROD_W-1:0]  speed_ext, speed_sum;
  logic [SPEED_W-1:0] next_d;
  logic               snap;

  assign in_fire  = in_i.valid && in_ready;
  assign resp_eff = (resp_q < RESP_FLOOR) ? RESP_FLOOR : resp_q;
  assign t_in     = in_i.speed_tgt[ACC_W-1] ? '0 : in_i.speed_tgt[SPEED_W-1:0];

  // speed error
  assign err_neg = t_q < speed_q;
  assign err_mag = err_neg ? (speed_q - t_q) : (t_q - speed_q);

  // desired acceleration, clamped to the limit on its side
  assign des_lim   = err_neg_q ? decel_lim_q : accel_lim_q;
  assign des_mag   = (div_quo > {{(PROD_W-LIM_W){1'b0}}, des_lim}) ? des_lim
                                                                    : div_quo[LIM_W-1:0];
  assign desired_d = err_neg_q ? (ACC_W'(0) - {1'b0, des_mag}) : {1'b0, des_mag};

  // acceleration change, bounded by jerk times step
  assign diff     = {desired_q[ACC_W-1], desired_q} - {accel_q[ACC_W-1], accel_q};
  assign diff_abs = diff[ACC_W] ? ((ACC_W+1)'(0) - diff) : diff;
  assign diff_mag = diff_abs[ACC_W-1:0];
  assign step_mag = (div_quo < {{(PROD_W-ACC_W){1'b0}}, diff_mag}) ? div_quo[ACC_W-1:0]
                                                                    : diff_mag;
  assign step_d   = diff[ACC_W] ? ((ACC_W+1)'(0) - {1'b0, step_mag}) : {1'b0, step_mag};

  assign acc_sum = {step_q[ACC_W], step_q} + {{2{accel_q[ACC_W-1]}}, accel_q};
  always_comb begin
    if (acc_sum[ACC_W+1:ACC_W-1] == 3'b000 || acc_sum[ACC_W+1:ACC_W-1] == 3'b111) begin
      acc_d = acc_sum[ACC_W-1:0];
    end else begin
      acc_d = acc_sum[ACC_W+1] ? ACC_MIN : ACC_MAX;
    end
  end
  assign acc_mag = acc_q[ACC_W-1] ? (ACC_W'(0) - acc_q) : acc_q;

  // integrated speed, saturated at both ends
  assign speed_ext = {{(PROD_W-SPEED_W){1'b0}}, speed_q};
  assign speed_sum = speed_ext + div_quo;
  always_comb begin
    if (acc_q[ACC_W-1]) begin
      next_d = (div_quo >= speed_ext) ? '0 : (speed_q - div_quo[SPEED_W-1:0]);
    end else begin
      next_d = (speed_sum > {{(PROD_W-SPEED_W){1'b0}}, SPEED_MAX}) ? SPEED_MAX
                                                                  : speed_sum[SPEED_W-1:0];
    end
  end

  // reached or crossed the target
  assign snap = err_zero_q || (t_q == next_q) || (err_neg_q != (t_q < next_q));

  always_comb begin
    state_d   = state_q;
    in_ready  = 1'b0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_den   = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          if (in_i.mode || !primed_q || in_i.step_ms == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_ERR;
          end
        end
      end
      ST_ERR: begin
        mul_start = 1'b1;
        mul_a     = {1'b0, err_mag};
        mul_b     = MS_PER_S;
        state_d   = ST_MUL_ERR;
      end
      ST_MUL_ERR: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_den   = resp_eff;
          state_d   = ST_DIV_ERR;
        end
      end
      ST_DIV_ERR: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = jerk_lim_q;
          mul_b     = dt_q;
          state_d   = ST_MUL_JERK;
        end
      end
      ST_MUL_JERK: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_den   = MS_PER_S;
          state_d   = ST_DIV_JERK;
        end
      end
      ST_DIV_JERK: begin
        if (div_done) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        state_d = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        mul_start = 1'b1;
        mul_a     = acc_mag;
        mul_b     = dt_q;
        state_d   = ST_MUL_ACC;
      end
      ST_MUL_ACC: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_den   = MS_PER_S;
          state_d   = ST_DIV_ACC;
        end
      end
      ST_DIV_ACC: begin
        if (div_done) begin
          state_d = ST_SNAP;
        end
      end
      ST_SNAP: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_lim_q <= ACCEL_LIMIT_RST;
      decel_lim_q <= DECEL_LIMIT_RST;
      jerk_lim_q  <= JERK_LIMIT_RST;
      resp_q      <= RESPONSE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ACCEL_LIMIT: accel_lim_q <= cfg_data_i[LIM_W-1:0];
        CFG_DECEL_LIMIT: decel_lim_q <= cfg_data_i[LIM_W-1:0];
        CFG_JERK_LIMIT:  jerk_lim_q  <= cfg_data_i[JERK_W-1:0];
        CFG_RESPONSE_MS: resp_q      <= cfg_data_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q    <= 1'b0;
      speed_q     <= '0;
      accel_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire && (in_i.mode || !primed_q)) begin
        primed_q <= 1'b1;
        speed_q  <= t_in;
        accel_q  <= '0;
      end else if (state_q == ST_SNAP) begin
        speed_q <= snap ? t_q : next_q;
        accel_q <= snap ? '0 : acc_q;
      end
      if (state_q == ST_DONE && state_d == ST_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      t_q  <= t_in;
      dt_q <= in_i.step_ms;
    end
    if (state_q == ST_ERR) begin
      err_neg_q  <= err_neg;
      err_zero_q <= (t_q == speed_q);
    end
    if (state_q == ST_DIV_ERR && div_done) begin
      desired_q <= desired_d;
    end
    if (state_q == ST_DIV_JERK && div_done) begin
      step_q <= step_d;
    end
    if (state_q == ST_ACC) begin
      acc_q <= acc_d;
    end
    if (state_q == ST_DIV_ACC && div_done) begin
      next_q <= next_d;
    end
    if (state_q == ST_DONE && state_d == ST_IDLE) begin
      out_speed_q <= speed_q;
      out_accel_q <= accel_q;
    end
  end

  jlsf_serial_mul #(
    .W (OPND_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  jlsf_serial_div #(
    .NW (PROD_W),
    .DW (OPND_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mul_prod),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.speed_cmd = out_speed_q;
  assign out_o.accel_now = out_accel_q;

  // multiplier finishes only while the sequencer waits on it
  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_MUL_ERR || state_q == ST_MUL_JERK || state_q == ST_MUL_ACC))
    else $error("multiplier finished outside a multiply state");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV_ERR || state_q == ST_DIV_JERK || state_q == ST_DIV_ACC))
    else $error("divider finished outside a divide state");

  a_reset_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.mode) |=> (primed_q && accel_q == '0 && speed_q == $past(t_in)))
    else $error("reset request did not load the speed state");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && state_d == ST_IDLE) |=>
      (out_valid_q && out_speed_q == $past(speed_q) && out_accel_q == $past(accel_q)))
    else $error("result register does not match the filter state");

endmodule

`default_nettype wire

### hdl/jlsf_serial_mul.sv
// ----------------------------------------------------------------------------
// jlsf_serial_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jlsf_serial_mul #(
  parameter int W = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [W-1:0]   a_i,
  input  wire logic [W-1:0]   b_i,
  output logic                done_o,
  output logic [2*W-1:0]      prod_o
);

  localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]     a_q;
  logic [2*W-1:0]   acc_q, acc_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [W:0]       sum;

  // upper half accumulates, lower half holds the remaining multiplier bits
  assign sum   = {1'b0, acc_q[2*W-1:W]} + (acc_q[0] ? {1'b0, a_q} : '0);
  assign acc_d = {sum, acc_q[W-1:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      acc_q <= {{W{1'b0}}, b_i};
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

### hdl/jlsf_serial_div.sv
// ----------------------------------------------------------------------------
// jlsf_serial_div
// Unsigned restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`default_nettype none

module jlsf_serial_div #(
  parameter int NW = 32,
  parameter int DW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic [NW-1:0]      quo_o
);

  localparam int CNT_W = (NW > 1) ? $clog2(NW) : 1;

  logic [NW-1:0]    quo_q;
  logic [DW-1:0]    rem_q, den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DW:0]      rem_sh;
  logic [DW+1:0]    trial;
  logic             qbit;

  assign rem_sh = {rem_q, quo_q[NW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den_q};
  assign qbit   = !trial[DW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder stays below a nonzero divisor, so DW bits hold it
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], qbit};
      rem_q <= qbit ? trial[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire
